// ===== hdl/rhc_pkg.sv =====
package rhc_pkg;

	localparam int NUM_STAGES = 5;

	localparam logic CMD_RGB2HSL = 1'b0;
	localparam logic CMD_HSL2RGB = 1'b1;

	localparam logic [14:0] HUE_FULL       = 15'd23040;
	localparam logic [14:0] HUE_SIXTH      = 15'd3840;
	localparam logic [14:0] HUE_THIRD      = 15'd7680;
	localparam logic [14:0] HUE_HALF       = 15'd11520;
	localparam logic [14:0] HUE_TWO_THIRDS = 15'd15360;
	localparam logic [14:0] PCT_FULL       = 15'd25600;
	localparam logic [14:0] PCT_HALF       = 15'd12800;

	// channel = round(v * 255 / (25600^2 * 3840)); 2*den = 2^29 * 9375
	localparam logic [50:0] CH_RND   = 51'd9375 << 27;
	localparam logic [13:0] CH_DIV   = 14'd9375;
	localparam logic [8:0]  CH_RECIP = 9'd447;     // floor(2^22 / 9375)

	localparam logic [7:0]  LUM_DIV   = 8'd255;
	localparam logic [16:0] LUM_RECIP = 17'd65793; // floor(2^24 / 255)

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctrl_t;

endpackage

// ===== hdl/rhc_hsl2rgb.sv =====
module rhc_hsl2rgb
	import rhc_pkg::*;
(
	input  logic        clk,
	input  pipe_ctrl_t  ctrl,
	input  logic [14:0] hue_in,
	input  logic [14:0] sat_in,
	input  logic [14:0] lum_in,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	function automatic logic [11:0] ramp_frac(input logic [14:0] t);
		logic [11:0] f;
		if (t < HUE_SIXTH) begin
			f = t[11:0];
		end else if (t < HUE_HALF) begin
			f = HUE_SIXTH[11:0];
		end else if (t < HUE_TWO_THIRDS) begin
			f = 12'(HUE_TWO_THIRDS - t);
		end else begin
			f = '0;
		end
		return f;
	endfunction

	// stage 1: clamp, hue offsets, m*s where hi = l*P + m*s, lo = l*P - m*s
	logic [14:0] h, s, l, m, t_r, t_b;
	logic [28:0] ms;
	logic [28:0] ms_s1;
	logic [14:0] l_s1;
	logic [11:0] f_s1 [3];

	always_comb begin
		h = (hue_in >= HUE_FULL) ? hue_in - HUE_FULL : hue_in;
		s = (sat_in > PCT_FULL) ? PCT_FULL : sat_in;
		l = (lum_in > PCT_FULL) ? PCT_FULL : lum_in;
		m = (l <= PCT_HALF) ? l : PCT_FULL - l;
		ms = {14'd0, m} * {14'd0, s};
		t_r = h + HUE_THIRD;
		if (t_r > HUE_FULL) begin
			t_r = t_r - HUE_FULL;
		end
		t_b = (h >= HUE_THIRD) ? h - HUE_THIRD : h + HUE_TWO_THIRDS;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			ms_s1   <= ms;
			l_s1    <= l;
			f_s1[0] <= ramp_frac(t_r);
			f_s1[1] <= ramp_frac(h);
			f_s1[2] <= ramp_frac(t_b);
		end
	end

	// stage 2: low level and m*s * fraction (span = 2*m*s, doubled in stage 3)
	logic [29:0] lo;
	logic [40:0] prod [3];
	logic [29:0] lo_s2;
	logic [40:0] prod_s2 [3];

	always_comb begin
		lo = {15'd0, l_s1} * {15'd0, PCT_FULL} - {1'b0, ms_s1};
		for (int c = 0; c < 3; c++) begin
			prod[c] = {12'd0, ms_s1} * {29'd0, f_s1[c]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			lo_s2 <= lo;
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= prod[c];
			end
		end
	end

	// stage 3: v*255 plus half the divisor, drop the 2^28 factor
	logic [41:0] v [3];
	logic [50:0] w [3];
	logic [21:0] x_s3 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			v[c] = {12'd0, lo_s2} * {27'd0, HUE_SIXTH} + {prod_s2[c], 1'b0};
			w[c] = {1'b0, v[c], 8'd0} - {9'd0, v[c]} + CH_RND;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			for (int c = 0; c < 3; c++) begin
				x_s3[c] <= w[c][49:28];
			end
		end
	end

	// stage 4: reciprocal estimate of x / 9375, low by at most one
	logic [30:0] pq [3];
	logic [8:0]  q_s4 [3];
	logic [21:0] x_s4 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pq[c] = {9'd0, x_s3[c]} * {22'd0, CH_RECIP};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			for (int c = 0; c < 3; c++) begin
				q_s4[c] <= pq[c][30:22];
				x_s4[c] <= x_s3[c];
			end
		end
	end

	// stage 5: remainder check
	logic [22:0] qd [3];
	logic [22:0] rem [3];
	logic [8:0]  qf [3];
	logic [7:0]  ch_s5 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qd[c]  = {14'd0, q_s4[c]} * {9'd0, CH_DIV};
			rem[c] = {1'b0, x_s4[c]} - qd[c];
			qf[c]  = (rem[c] >= {9'd0, CH_DIV}) ? q_s4[c] + 9'd1 : q_s4[c];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			for (int c = 0; c < 3; c++) begin
				ch_s5[c] <= qf[c][7:0];
			end
		end
	end

	assign red   = ch_s5[0];
	assign green = ch_s5[1];
	assign blue  = ch_s5[2];

endmodule

// ===== hdl/rhc_rgb2hsl.sv =====
module rhc_rgb2hsl
	import rhc_pkg::*;
(
	input  logic        clk,
	input  pipe_ctrl_t  ctrl,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic [14:0] hue,
	output logic [14:0] sat,
	output logic [14:0] lum
);

	// floor(2^23 / n): reciprocal of the doubled divisor 2n at 2^24
	logic [23:0] recip_tab [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_recip
		localparam int unsigned RDIV = (gi == 0) ? 1 : gi;
		localparam int unsigned RVAL = (gi == 0) ? 0 : (2 ** 23) / RDIV;
		assign recip_tab[gi] = 24'(RVAL);
	end

	// stage 1: max/min, hue sector numerator k (hue = 60 deg * k / d)
	logic [7:0]  mx, mn, d, den;
	logic [8:0]  sum;
	logic [12:0] d2, d4;
	logic signed [12:0] e;
	logic [22:0] lumx;

	logic [7:0]  d_s1, den_s1;
	logic [10:0] k_s1;
	logic        grey_s1;
	logic [22:0] lumx_s1;

	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx) mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn) mn = blue_in;
		sum = {1'b0, mx} + {1'b0, mn};
		d = mx - mn;
		den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		d2 = {4'd0, d, 1'b0};
		d4 = {3'd0, d, 2'd0};
		if (red_in == mx) begin
			e = $signed({5'd0, green_in}) - $signed({5'd0, blue_in});
			if (e < 0) begin
				e = e + $signed(d4 + d2);
			end
		end else if (green_in == mx) begin
			e = $signed(d2 + {5'd0, blue_in}) - $signed({5'd0, red_in});
		end else begin
			e = $signed(d4 + {5'd0, red_in}) - $signed({5'd0, green_in});
		end
		// lum = floor((sum*12800 + 127) / 255)
		lumx = {14'd0, sum} * 23'(PCT_HALF) + 23'd127;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			d_s1    <= d;
			den_s1  <= den;
			k_s1    <= e[10:0];
			grey_s1 <= (mx == mn);
			lumx_s1 <= lumx;
		end
	end

	// stage 2: numerators, reciprocal lookup, luminance estimate
	logic [23:0] n_sat, n_hue;
	logic [39:0] lp;
	logic [23:0] nsat_s2, nhue_s2, rsat_s2, rhue_s2;
	logic [8:0]  dsat_s2, dhue_s2;
	logic        grey_s2;
	logic [22:0] lumx_s2;
	logic [15:0] lumq_s2;

	always_comb begin
		n_sat = {16'd0, d_s1} * 24'd51200 + {16'd0, den_s1};
		n_hue = {13'd0, k_s1} * 24'(HUE_THIRD) + {16'd0, d_s1};
		lp = {17'd0, lumx_s1} * {23'd0, LUM_RECIP};
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			nsat_s2 <= n_sat;
			nhue_s2 <= n_hue;
			rsat_s2 <= recip_tab[den_s1];
			rhue_s2 <= recip_tab[d_s1];
			dsat_s2 <= {den_s1, 1'b0};
			dhue_s2 <= {d_s1, 1'b0};
			grey_s2 <= grey_s1;
			lumx_s2 <= lumx_s1;
			lumq_s2 <= lp[39:24];
		end
	end

	// stage 3: quotient estimates, low by at most one
	logic [47:0] psat, phue;
	logic [15:0] qsat_s3, qhue_s3;
	logic [23:0] nsat_s3, nhue_s3;
	logic [8:0]  dsat_s3, dhue_s3;
	logic        grey_s3;
	logic [22:0] lumx_s3;
	logic [15:0] lumq_s3;

	always_comb begin
		psat = {24'd0, nsat_s2} * {24'd0, rsat_s2};
		phue = {24'd0, nhue_s2} * {24'd0, rhue_s2};
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			qsat_s3 <= psat[39:24];
			qhue_s3 <= phue[39:24];
			nsat_s3 <= nsat_s2;
			nhue_s3 <= nhue_s2;
			dsat_s3 <= dsat_s2;
			dhue_s3 <= dhue_s2;
			grey_s3 <= grey_s2;
			lumx_s3 <= lumx_s2;
			lumq_s3 <= lumq_s2;
		end
	end

	// stage 4: back-multiply; luminance correction finishes here
	logic [24:0] bsat, bhue;
	logic [23:0] lq255, lrem;
	logic [15:0] lumf;
	logic [24:0] bsat_s4, bhue_s4;
	logic [15:0] qsat_s4, qhue_s4;
	logic [23:0] nsat_s4, nhue_s4;
	logic [8:0]  dsat_s4, dhue_s4;
	logic        grey_s4;
	logic [14:0] lum_s4;

	always_comb begin
		bsat  = {9'd0, qsat_s3} * {16'd0, dsat_s3};
		bhue  = {9'd0, qhue_s3} * {16'd0, dhue_s3};
		lq255 = {8'd0, lumq_s3} * {16'd0, LUM_DIV};
		lrem  = {1'b0, lumx_s3} - lq255;
		lumf  = (lrem >= {16'd0, LUM_DIV}) ? lumq_s3 + 16'd1 : lumq_s3;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			bsat_s4 <= bsat;
			bhue_s4 <= bhue;
			qsat_s4 <= qsat_s3;
			qhue_s4 <= qhue_s3;
			nsat_s4 <= nsat_s3;
			nhue_s4 <= nhue_s3;
			dsat_s4 <= dsat_s3;
			dhue_s4 <= dhue_s3;
			grey_s4 <= grey_s3;
			lum_s4  <= lumf[14:0];
		end
	end

	// stage 5: remainder checks, grey and hue wrap
	logic [23:0] rsat, rhue;
	logic [15:0] qs, qh;
	logic [14:0] sat_s5, hue_s5, lum_s5;

	always_comb begin
		rsat = nsat_s4 - bsat_s4[23:0];
		rhue = nhue_s4 - bhue_s4[23:0];
		qs = (rsat >= {15'd0, dsat_s4}) ? qsat_s4 + 16'd1 : qsat_s4;
		qh = (rhue >= {15'd0, dhue_s4}) ? qhue_s4 + 16'd1 : qhue_s4;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			lum_s5 <= lum_s4;
			if (grey_s4) begin
				sat_s5 <= '0;
				hue_s5 <= '0;
			end else begin
				sat_s5 <= qs[14:0];
				hue_s5 <= (qh[14:0] == HUE_FULL) ? '0 : qh[14:0];
			end
		end
	end

	assign hue = hue_s5;
	assign sat = sat_s5;
	assign lum = lum_s5;

endmodule

// ===== hdl/rgb_hsl_converter.sv =====
// RGB <-> HSL pixel converter. One request per pixel; tuser selects the
// direction (0: RGB to HSL, 1: HSL to RGB). Five-stage pipeline: one pixel
// is taken every clock while the output side keeps up. Each stage holds
// only while the one after it is full and stalled, so empty slots close
// up and the input keeps flowing until the whole pipe is full. The
// saturation and hue quotients use a 256-entry reciprocal table and a
// one-step remainder correction, spread over stages 2 to 5.
module rgb_hsl_converter
	import rhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// red[7:0] green[15:8] blue[23:16] hue[38:24] sat[53:39] lum[68:54], pad
	input  logic [71:0] s_tdata,
	// command[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// red[7:0] green[15:8] blue[23:16] hue[38:24] sat[53:39] lum[68:54], pad
	output logic [71:0] m_tdata
);

	logic [NUM_STAGES-1:0] vld_q;
	logic                  cmd_q [NUM_STAGES];
	pipe_ctrl_t            ctrl;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		ctrl.en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			ctrl.en[i] = !vld_q[i] || ctrl.en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctrl.en[0]) vld_q[0] <= s_tvalid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (ctrl.en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) cmd_q[0] <= s_tuser[0];
		for (int i = 1; i < NUM_STAGES; i++) begin
			if (ctrl.en[i]) cmd_q[i] <= cmd_q[i-1];
		end
	end

	logic [7:0]  red, green, blue;
	logic [14:0] hue, sat, lum;

	rhc_hsl2rgb u_hsl2rgb (
		.clk    (clk),
		.ctrl   (ctrl),
		.hue_in (s_tdata[38:24]),
		.sat_in (s_tdata[53:39]),
		.lum_in (s_tdata[68:54]),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	rhc_rgb2hsl u_rgb2hsl (
		.clk      (clk),
		.ctrl     (ctrl),
		.red_in   (s_tdata[7:0]),
		.green_in (s_tdata[15:8]),
		.blue_in  (s_tdata[23:16]),
		.hue      (hue),
		.sat      (sat),
		.lum      (lum)
	);

	logic last_hsl;
	assign last_hsl = (cmd_q[NUM_STAGES-1] == CMD_HSL2RGB);

	assign s_tready = ctrl.en[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];
	assign m_tdata  = {3'd0,
		last_hsl ? 15'd0 : lum,
		last_hsl ? 15'd0 : sat,
		last_hsl ? 15'd0 : hue,
		last_hsl ? blue : 8'd0,
		last_hsl ? green : 8'd0,
		last_hsl ? red : 8'd0};

endmodule
